// ===== rtl/vaft_pkg.sv =====
// Shared types and constants for the vector angle pipeline.
// Holds angle constants, the arctangent table and register index codes.
// No dependencies.
package vaft_pkg;

   // Field and register widths.
   localparam int ANGLE_WIDTH = 19;
   localparam int ZT_WIDTH    = 15;
   localparam int ST_WIDTH    = 13;
   localparam int CSR_DATA_WIDTH = 15;

   // Angle accumulator: signed, units of 2^-24 rad.
   localparam int Z_WIDTH     = 28;
   // Full-turn angle in 2^-24 rad fits in 27 bits.
   localparam int FULL_WIDTH  = 27;
   localparam int QA_WIDTH    = 26;

   localparam int ATAN_TABLE_LEN = 24;

   // Angle constants in 2^-24 rad.
   localparam logic [FULL_WIDTH-1:0] HALF_PI_24 = 27'd26353589;
   localparam logic [FULL_WIDTH-1:0] PI_24      = 27'd52707179;
   localparam logic [FULL_WIDTH-1:0] TWO_PI_24  = 27'd105414357;

   // Axis angles and full turn in 2^-16 rad.
   localparam logic [ANGLE_WIDTH-1:0] AXIS_Q0   = 19'd0;
   localparam logic [ANGLE_WIDTH-1:0] AXIS_Q1   = 19'd102944;
   localparam logic [ANGLE_WIDTH-1:0] AXIS_Q2   = 19'd205887;
   localparam logic [ANGLE_WIDTH-1:0] AXIS_Q3   = 19'd308831;
   localparam logic [ANGLE_WIDTH-1:0] FULL_TURN = 19'd411775;

   // Rounded arctangent of 2^-i in 2^-24 rad.
   localparam logic [24:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
      25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331,
      25'd1047214,  25'd524117,  25'd262123,  25'd131069,
      25'd65536,    25'd32768,   25'd16384,   25'd8192,
      25'd4096,     25'd2048,    25'd1024,    25'd512,
      25'd256,      25'd128,     25'd64,      25'd32,
      25'd16,       25'd8,       25'd4,       25'd2
   };

   // Configuration register indexes.
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_ZERO_THRESHOLD = 1'b0;
   localparam csr_index_type CSR_SNAP_TOLERANCE = 1'b1;

   // Per-item flags that travel beside the CORDIC data.
   typedef struct packed {
      logic zero_vec;
      logic x_neg;
      logic y_neg;
      logic y_axis;
      logic x_axis;
   } flags_type;

endpackage

// ===== rtl/vector_angle_full_turn.sv =====
// Path from request to response: input register, the CORDIC stages, quadrant stage, output register.
// Throughput: one transaction per cycle; one CORDIC iteration per pipeline stage.
// A stall on the response side freezes the whole pipeline, nothing is dropped.
// Reset clears all valid bits and sets zero_threshold to 0, snap_tolerance to 1.
// Depends on vaft_pkg.
module vector_angle_full_turn #(
   parameter int COORD_WIDTH   = 16,
   parameter int CORDIC_STAGES = 18
) (
   input  logic clock,
   input  logic reset,

   // Request stream.
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0: vec_x, vec_y, zero padding.
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,

   // Response stream.
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // Fields from bit 0: angle, zero padding.
   output logic [((vaft_pkg::ANGLE_WIDTH+7)/8)*8-1:0] rsp_tdata,

   // Configuration write channel.
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  vaft_pkg::csr_index_type                  csr_index,
   input  logic [vaft_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);
   import vaft_pkg::*;

   // Magnitudes are scaled to reach 2^59; the iterations grow them by less than 2.4.
   localparam int FRAC = 60 - COORD_WIDTH;
   localparam int CW   = 63;
   localparam int PAD  = CW - COORD_WIDTH - FRAC;
   localparam int MW   = COORD_WIDTH + ZT_WIDTH;
   localparam int RSP_DW = ((ANGLE_WIDTH + 7) / 8) * 8;

   // Configuration registers.
   logic [ZT_WIDTH-1:0] zero_thr_ff;
   logic [ST_WIDTH-1:0] snap_tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_thr_ff <= '0;
         snap_tol_ff <= ST_WIDTH'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ZERO_THRESHOLD: zero_thr_ff <= csr_data[ZT_WIDTH-1:0];
            CSR_SNAP_TOLERANCE: snap_tol_ff <= csr_data[ST_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Whole pipeline moves when the output register is free or being drained.
   logic adv;
   logic out_valid_ff;
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Input stage: fold to magnitudes and classify.
   logic signed [COORD_WIDTH-1:0] vec_x, vec_y;
   logic [COORD_WIDTH-1:0]        ax, ay;
   flags_type                     flags_in;

   assign vec_x = req_tdata[COORD_WIDTH-1:0];
   assign vec_y = req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

   always_comb begin
      ax = vec_x[COORD_WIDTH-1] ? COORD_WIDTH'(-vec_x) : COORD_WIDTH'(vec_x);
      ay = vec_y[COORD_WIDTH-1] ? COORD_WIDTH'(-vec_y) : COORD_WIDTH'(vec_y);
      flags_in.zero_vec = (MW'(ax) <= MW'(zero_thr_ff)) && (MW'(ay) <= MW'(zero_thr_ff));
      flags_in.x_neg    = vec_x[COORD_WIDTH-1];
      flags_in.y_neg    = vec_y[COORD_WIDTH-1];
      flags_in.y_axis   = (ay == '0);
      flags_in.x_axis   = (ax == '0);
   end

   // CORDIC stage registers; entry 0 is the input register.
   logic                  valid_ff [0:CORDIC_STAGES];
   logic signed [CW-1:0]  cx_ff    [0:CORDIC_STAGES];
   logic signed [CW-1:0]  cy_ff    [0:CORDIC_STAGES];
   logic signed [Z_WIDTH-1:0] z_ff [0:CORDIC_STAGES];
   flags_type             flags_ff [0:CORDIC_STAGES];

   // Load the input register with magnitudes scaled by 2^FRAC.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0]    <= $signed({{PAD{1'b0}}, ax, {FRAC{1'b0}}});
         cy_ff[0]    <= $signed({{PAD{1'b0}}, ay, {FRAC{1'b0}}});
         z_ff[0]     <= '0;
         flags_ff[0] <= flags_in;
      end
   end

   // One vectoring iteration per stage; the shifts round toward minus infinity.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      logic signed [CW-1:0]      cx_in, cy_in;
      logic signed [Z_WIDTH-1:0] z_in;
      logic signed [Z_WIDTH-1:0] step;

      always_comb begin
         step = $signed(Z_WIDTH'(ATAN_TABLE[i]));
         if (!cy_ff[i][CW-1]) begin
            cx_in = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in = cy_ff[i] - (cx_ff[i] >>> i);
            z_in  = z_ff[i] + step;
         end else begin
            cx_in = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in = cy_ff[i] + (cx_ff[i] >>> i);
            z_in  = z_ff[i] - step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (adv) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      // Flags pass through the iterations unchanged.
      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[i+1]    <= cx_in;
            cy_ff[i+1]    <= cy_in;
            z_ff[i+1]     <= z_in;
            flags_ff[i+1] <= flags_ff[i];
         end
      end
   end

   // Quadrant stage: clamp, handle exact axes, unfold and round.
   logic                   quad_valid_ff;
   logic [ANGLE_WIDTH-1:0] quad_angle_ff;
   logic                   quad_zero_ff;

   logic signed [Z_WIDTH-1:0] z_end;
   flags_type                 f_end;
   logic [QA_WIDTH-1:0]       qa;
   logic [FULL_WIDTH-1:0]     full;
   logic [FULL_WIDTH:0]       full_rnd;
   logic [ANGLE_WIDTH-1:0]    quad_angle_in;

   always_comb begin
      z_end = z_ff[CORDIC_STAGES];
      f_end = flags_ff[CORDIC_STAGES];
      if (f_end.y_axis) begin
         qa = '0;
      end else if (f_end.x_axis) begin
         qa = QA_WIDTH'(HALF_PI_24);
      end else if (z_end[Z_WIDTH-1]) begin
         qa = '0;
      end else if (z_end > $signed(Z_WIDTH'(HALF_PI_24))) begin
         qa = QA_WIDTH'(HALF_PI_24);
      end else begin
         qa = QA_WIDTH'(z_end);
      end
      case ({f_end.x_neg, f_end.y_neg})
         2'b00:   full = FULL_WIDTH'(qa);
         2'b01:   full = TWO_PI_24 - FULL_WIDTH'(qa);
         2'b10:   full = PI_24 - FULL_WIDTH'(qa);
         default: full = PI_24 + FULL_WIDTH'(qa);
      endcase
      full_rnd      = (FULL_WIDTH+1)'(full) + (FULL_WIDTH+1)'(128);
      quad_angle_in = full_rnd[ANGLE_WIDTH+7:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_valid_ff <= 1'b0;
      end else if (adv) begin
         quad_valid_ff <= valid_ff[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quad_angle_ff <= quad_angle_in;
         quad_zero_ff  <= f_end.zero_vec;
      end
   end

   // Snap stage: nearest axis by priority, full turn wraps to zero.
   function automatic logic near_axis(input logic [ANGLE_WIDTH-1:0] a,
                                      input logic [ANGLE_WIDTH-1:0] axis,
                                      input logic [ST_WIDTH-1:0]    tol);
      logic [ANGLE_WIDTH-1:0] d;
      d = (a > axis) ? (a - axis) : (axis - a);
      return d <= ANGLE_WIDTH'(tol);
   endfunction

   logic [ANGLE_WIDTH-1:0] snap_angle;
   logic [ANGLE_WIDTH-1:0] out_angle_in;

   always_comb begin
      if (near_axis(quad_angle_ff, AXIS_Q0, snap_tol_ff)) begin
         snap_angle = AXIS_Q0;
      end else if (near_axis(quad_angle_ff, AXIS_Q1, snap_tol_ff)) begin
         snap_angle = AXIS_Q1;
      end else if (near_axis(quad_angle_ff, AXIS_Q2, snap_tol_ff)) begin
         snap_angle = AXIS_Q2;
      end else if (near_axis(quad_angle_ff, AXIS_Q3, snap_tol_ff)) begin
         snap_angle = AXIS_Q3;
      end else if (near_axis(quad_angle_ff, FULL_TURN, snap_tol_ff)) begin
         snap_angle = AXIS_Q0;
      end else begin
         snap_angle = quad_angle_ff;
      end
      if (quad_zero_ff || snap_angle >= FULL_TURN) begin
         out_angle_in = '0;
      end else begin
         out_angle_in = snap_angle;
      end
   end

   // Output register.
   logic [ANGLE_WIDTH-1:0] out_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= quad_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_angle_ff <= out_angle_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DW'(out_angle_ff);

endmodule

// ===== tb/sv/vector_angle_full_turn_test.sv =====
// Self-checking testbench for vector_angle_full_turn: a directed table, then random vectors.
// A CORDIC predictor, or the typed-in angle of a table row, checks every response stream transaction.
// Depends on vaft_pkg and the vector_angle_full_turn RTL.
module vector_angle_full_turn_test;
   import vaft_pkg::*;

   localparam int COORD_W = 16;
   localparam int STAGES  = 18;
   localparam int ANGLE_W = 19;
   localparam int PHASE_ITEMS = 225;
   localparam int PHASE_COUNT = 8;

   // Angle constants: 2^-24 rad for the accumulator, 2^-16 rad for results.
   localparam longint QUARTER_Q24 = 64'd26353589;
   localparam longint HALF_Q24    = 64'd52707179;
   localparam longint TURN_Q24    = 64'd105414357;
   localparam logic [ANGLE_W-1:0] HEADING_E = 19'd0;
   localparam logic [ANGLE_W-1:0] HEADING_N = 19'd102944;
   localparam logic [ANGLE_W-1:0] HEADING_W = 19'd205887;
   localparam logic [ANGLE_W-1:0] HEADING_S = 19'd308831;
   localparam logic [ANGLE_W-1:0] TURN      = 19'd411775;

   // Arctangent of 2^-i, rounded to 2^-24 rad.
   localparam longint ARCTAN_Q24 [24] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      pinned;
      logic [ANGLE_W-1:0]        angle;
   } vector_case_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [31:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [23:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   csr_index_type csr_index;
   logic [14:0] csr_data;

   // Sideband that travels with each request: a typed-in angle for table rows.
   logic req_pinned;
   logic [ANGLE_W-1:0] req_pinned_angle;

   // Predictor copy of the registers and the angles still awaited.
   logic [14:0] zero_limit;
   logic [12:0] snap_limit;
   logic [ANGLE_W-1:0] pending_angles [$];
   int mismatch_count;
   int idle_pct;
   int stall_pct;

   // Directed table: axes and zero vector are typed in, the rest is predicted.
   vector_case_type directed_cases [0:23] = '{
      '{0, 0, 1'b1, HEADING_E},
      '{1, 0, 1'b1, HEADING_E},
      '{32767, 0, 1'b1, HEADING_E},
      '{-32768, 0, 1'b1, HEADING_W},
      '{-1, 0, 1'b1, HEADING_W},
      '{0, 1, 1'b1, HEADING_N},
      '{0, 32767, 1'b1, HEADING_N},
      '{0, -1, 1'b1, HEADING_S},
      '{0, -32768, 1'b1, HEADING_S},
      '{32767, 32767, 1'b0, 0},
      '{-32768, 32767, 1'b0, 0},
      '{-32768, -32768, 1'b0, 0},
      '{32767, -32768, 1'b0, 0},
      '{32767, 1, 1'b0, 0},
      '{32767, -1, 1'b0, 0},
      '{1, 32767, 1'b0, 0},
      '{-1, -32768, 1'b0, 0},
      '{-32768, 1, 1'b0, 0},
      '{1, 1, 1'b0, 0},
      '{-1, 1, 1'b0, 0},
      '{-1, -1, 1'b0, 0},
      '{1, -1, 1'b0, 0},
      '{21845, -10923, 1'b0, 0},
      '{-21846, 10922, 1'b0, 0}
   };

   vector_angle_full_turn #(
      .COORD_WIDTH  (COORD_W),
      .CORDIC_STAGES(STAGES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic logic near_heading(input longint r, input longint heading);
      longint d;
      d = (r > heading) ? r - heading : heading - r;
      return d <= longint'(snap_limit);
   endfunction

   // Direction angle of (vx, vy) in 2^-16 rad under the current register values.
   function automatic logic [ANGLE_W-1:0] predict_angle(input logic signed [COORD_W-1:0] vx,
                                                        input logic signed [COORD_W-1:0] vy);
      longint ax, ay, cx, cy, dx, dy, z, full, r;
      int rounds;
      ax = vx[COORD_W-1] ? -longint'(vx) : longint'(vx);
      ay = vy[COORD_W-1] ? -longint'(vy) : longint'(vy);
      if (ax <= longint'(zero_limit) && ay <= longint'(zero_limit)) return '0;

      // First-quadrant angle by vectoring CORDIC, clamped to [0, pi/2].
      z = 0;
      if (ay == 0) begin
         z = 0;
      end else if (ax == 0) begin
         z = QUARTER_Q24;
      end else begin
         rounds = (STAGES > 24) ? 24 : STAGES;
         cx = ax <<< (60 - COORD_W);
         cy = ay <<< (60 - COORD_W);
         for (int i = 0; i < rounds; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
               cx = cx + dx;
               cy = cy - dy;
               z = z + ARCTAN_Q24[i];
            end else begin
               cx = cx - dx;
               cy = cy + dy;
               z = z - ARCTAN_Q24[i];
            end
         end
         if (z < 0) z = 0;
         if (z > QUARTER_Q24) z = QUARTER_Q24;
      end

      // Place the angle in its quadrant by the component signs.
      if (!vx[COORD_W-1]) full = vy[COORD_W-1] ? TURN_Q24 - z : z;
      else full = vy[COORD_W-1] ? HALF_Q24 + z : HALF_Q24 - z;
      r = (full + 128) >>> 8;

      // Snap to the nearest axis heading; a full turn wraps to zero.
      if (near_heading(r, HEADING_E)) r = HEADING_E;
      else if (near_heading(r, HEADING_N)) r = HEADING_N;
      else if (near_heading(r, HEADING_W)) r = HEADING_W;
      else if (near_heading(r, HEADING_S)) r = HEADING_S;
      else if (near_heading(r, TURN)) r = 0;
      if (r >= TURN) r = 0;
      return r[ANGLE_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] saturate(input int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[COORD_W-1:0];
   endfunction

   // Random vector from full range, threshold edges, near/exact axes, extremes or shifts.
   task automatic draw_vector(input int zero_edge,
                              output logic signed [COORD_W-1:0] vx,
                              output logic signed [COORD_W-1:0] vy);
      int kind;
      int span;
      kind = $urandom_range(0, 9);
      span = zero_edge + 2;
      vx = COORD_W'($urandom);
      vy = COORD_W'($urandom);
      case (kind) inside
         4: begin
            vx = saturate(int'($urandom_range(0, 2 * span)) - span);
            vy = saturate(int'($urandom_range(0, 2 * span)) - span);
         end
         5: begin
            if ($urandom_range(0, 1)) vx = COORD_W'(int'($urandom_range(0, 16)) - 8);
            else vy = COORD_W'(int'($urandom_range(0, 16)) - 8);
         end
         6: begin
            case ($urandom_range(0, 5))
               0: vx = 16'sh8000;
               1: vx = 16'sh8001;
               2: vx = 16'shffff;
               3: vx = 16'sh0000;
               4: vx = 16'sh0001;
               default: vx = 16'sh7fff;
            endcase
            case ($urandom_range(0, 5))
               0: vy = 16'sh8000;
               1: vy = 16'sh8001;
               2: vy = 16'shffff;
               3: vy = 16'sh0000;
               4: vy = 16'sh0001;
               default: vy = 16'sh7fff;
            endcase
         end
         7: begin
            if ($urandom_range(0, 1)) vx = 16'sh0000;
            else vy = 16'sh0000;
         end
         8, 9: begin
            vx = $signed(vx) >>> $urandom_range(0, 15);
            vy = $signed(vy) >>> $urandom_range(0, 15);
         end
         default: ;
      endcase
   endtask

   // Offer one vector and hold it until the request transaction completes.
   task automatic send_vector(input logic signed [COORD_W-1:0] vx,
                              input logic signed [COORD_W-1:0] vy,
                              input logic pinned,
                              input logic [ANGLE_W-1:0] pinned_angle);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {vy, vx};
      req_pinned <= pinned;
      req_pinned_angle <= pinned_angle;
      do @(posedge clock); while (!req_tready);
   endtask

   // Offer one register write; the caller drops csr_valid after the last one.
   task automatic write_register(input csr_index_type idx, input logic [14:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Step past the current edge first so the transaction accepted at it is counted.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_angles.size() != 0) @(posedge clock);
   endtask

   // Receiver side: random backpressure at the rate of the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Track register writes, predict each accepted vector and check each response.
   always @(posedge clock) begin
      logic [ANGLE_W-1:0] wanted;
      if (reset) begin
         zero_limit <= '0;
         snap_limit <= 13'd1;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ZERO_THRESHOLD) zero_limit <= csr_data;
            else if (csr_index == CSR_SNAP_TOLERANCE) snap_limit <= csr_data[12:0];
         end
         if (req_tvalid && req_tready) begin
            if (req_pinned) pending_angles.push_back(req_pinned_angle);
            else pending_angles.push_back(predict_angle(req_tdata[15:0], req_tdata[31:16]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_angles.size() == 0) begin
               $error("angle: unexpected response %0d", rsp_tdata[ANGLE_W-1:0]);
               mismatch_count++;
            end else begin
               wanted = pending_angles.pop_front();
               if (rsp_tdata[ANGLE_W-1:0] !== wanted) begin
                  $error("angle: expected %0d, actual %0d", wanted, rsp_tdata[ANGLE_W-1:0]);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Stimulus: directed table at reset values, then random phases with new settings.
   initial begin
      logic signed [COORD_W-1:0] vx, vy;
      logic [14:0] zt;
      logic [14:0] st;
      mismatch_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_pinned = 1'b0;
      req_pinned_angle = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ZERO_THRESHOLD;
      csr_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_cases[i]) begin
         send_vector(directed_cases[i].x, directed_cases[i].y,
                     directed_cases[i].pinned, directed_cases[i].angle);
      end
      req_tvalid <= 1'b0;
      req_pinned <= 1'b0;
      wait_drained();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin zt = 0;     st = 1;    end
            1: begin zt = 32767; st = 4096; end
            2: begin zt = 0;     st = 0;    end
            3: begin zt = 15;    st = 4096; end
            4: begin zt = 1000;  st = 7;    end
            6: begin zt = 32767; st = 0;    end
            7: begin
               zt = 15'($urandom_range(0, 64));
               st = 15'($urandom_range(0, 64));
            end
            default: begin
               zt = 15'($urandom_range(0, 32767));
               st = 15'($urandom_range(0, 4096));
            end
         endcase
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 60; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 60; end
            default: begin idle_pct = 33; stall_pct = 33; end
         endcase
         write_register(CSR_ZERO_THRESHOLD, zt);
         write_register(CSR_SNAP_TOLERANCE, st);
         csr_valid <= 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            draw_vector(int'(zt), vx, vy);
            send_vector(vx, vy, 1'b0, '0);
         end
         req_tvalid <= 1'b0;
         wait_drained();
      end

      // Let the pipeline run dry and catch any response nobody asked for.
      stall_pct = 0;
      repeat (STAGES + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("vector_angle_full_turn regression: pass");
      end else begin
         $display("vector_angle_full_turn regression: fail");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(12 * 400000);
      $display("vector_angle_full_turn regression: fail");
      $finish;
   end

endmodule
